@@ rtl/whp_pkg.sv @@
// Shared types and constants of the WAVE header parser.
package whp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] MIN_FILE_LEN = 32'd44;
    localparam logic [3:0]  FMT_BODY_LEN = 4'd15;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MAGIC  = 3'd1,
        PH_HEADER = 3'd2,
        PH_FMT    = 3'd3,
        PH_SKIP   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_FMT_TRUNC = 3'd3,
        ST_FMT_SMALL = 3'd4,
        ST_MISSING   = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_flag;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] frame_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] data_offset;
        logic [31:0] data_length;
    } result_t;

endpackage

@@ rtl/wav_header_parser.sv @@
// Top level of the RIFF/WAVE header parser.
//
// The block takes one file byte per cycle for as long as the result side keeps
// up: each byte passes through an input register, one combinational parse step
// and a result register, whose valid bit is out_valid. A result waiting with
// out_ready low holds the parse step, and once the input register is also full
// in_ready drops until the result is taken. Bytes are parsed in order; a byte
// with first_flag set restarts the parse, and bytes after a result are dropped
// until the next first byte. Each file gives at most one result: on the data
// chunk header or on the first error found. Write file_length before the first
// byte of a file, while no request is in flight.
module wav_header_parser
    import whp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        file_length_we,
    input  logic [31:0] file_length_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        first_flag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] frame_rate,
    output logic [15:0] channel_count,
    output logic [15:0] sample_bits,
    output logic [31:0] data_offset,
    output logic [31:0] data_length
);

    logic    item_valid;
    item_t   item;
    logic    item_take;
    logic    stage_ready;
    logic    res_valid;
    result_t result;

    assign item_take = item_valid && stage_ready;

    whp_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .file_byte  (file_byte),
        .first_flag (first_flag),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    whp_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .file_length_we    (file_length_we),
        .file_length_wdata (file_length_wdata),
        .item_fire         (item_take),
        .item              (item),
        .res_valid         (res_valid),
        .result            (result)
    );

    whp_result_stage u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_load      (res_valid),
        .res_data      (result),
        .stage_ready   (stage_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .frame_rate    (frame_rate),
        .channel_count (channel_count),
        .sample_bits   (sample_bits),
        .data_offset   (data_offset),
        .data_length   (data_length)
    );

endmodule

@@ rtl/whp_input_stage.sv @@
// Input register that holds one byte request for the parse step.
module whp_input_stage
    import whp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] file_byte,
    input  logic       first_flag,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.file_byte  <= file_byte;
            item_reg.first_flag <= first_flag;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/whp_parser.sv @@
// Parse state of the RIFF/WAVE header and the combinational step for one byte.
module whp_parser
    import whp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        file_length_we,
    input  logic [31:0] file_length_wdata,
    input  logic        item_fire,
    input  item_t       item,
    output logic        res_valid,
    output result_t     result
);

    logic [31:0] file_length_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [3:0]  shift_reg, shift_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] bits_reg, bits_next;
    logic        fmt_seen_reg, fmt_seen_next;

    // Values as seen by the current byte; a first byte restarts everything.
    logic        first;
    logic [7:0]  b;
    logic        active;
    phase_t      cur_phase;
    logic [3:0]  cur_idx;
    logic [31:0] cur_pos;
    logic [31:0] cur_tag;
    logic [31:0] cur_skip;
    logic [31:0] cur_rate;
    logic [15:0] cur_chan;
    logic [15:0] cur_bits;
    logic        cur_fmt_seen;
    logic [4:0]  lane_base;
    logic [31:0] tag_asm;
    logic [31:0] size_asm;
    logic [32:0] body;
    logic [31:0] gap;
    logic [33:0] next_end;
    logic        overflow;
    logic        fmt_trunc;
    logic [31:0] skip_dec;
    logic        short_file;
    logic        hdr_end;
    logic        fmt_end;
    logic        err;
    status_t     err_code;

    assign first = item.first_flag;
    assign b     = item.file_byte;

    always_comb
    begin
        active       = item_fire && (first || (phase_reg != PH_IDLE && phase_reg != PH_DONE));
        cur_phase    = first ? PH_MAGIC : phase_reg;
        cur_idx      = first ? 4'd0 : shift_reg;
        cur_pos      = first ? 32'd0 : pos_reg + 32'd1;
        cur_tag      = first ? 32'd0 : tag_reg;
        cur_skip     = first ? 32'd0 : skip_reg;
        cur_rate     = first ? 32'd0 : rate_reg;
        cur_chan     = first ? 16'd0 : chan_reg;
        cur_bits     = first ? 16'd0 : bits_reg;
        cur_fmt_seen = first ? 1'b0 : fmt_seen_reg;
        short_file   = first && (file_length_reg < MIN_FILE_LEN);

        // Little-endian word assembly; lane zero clears the upper lanes.
        lane_base = {cur_idx[1:0], 3'b000};
        tag_asm   = (cur_idx[1:0] == 2'd0) ? 32'd0 : cur_tag;
        tag_asm[lane_base +: 8] = b;
        size_asm  = (cur_idx[1:0] == 2'd0) ? 32'd0 : cur_skip;
        size_asm[lane_base +: 8] = b;

        body      = {1'b0, cur_pos} + 33'd1;
        fmt_trunc = ({1'b0, body} + 34'd16) > {2'b00, file_length_reg};
        gap       = (cur_phase == PH_FMT) ? cur_skip : size_asm;
        next_end  = {1'b0, body} + {2'b00, gap} + 34'd8;
        overflow  = next_end > {2'b00, file_length_reg};
        skip_dec  = cur_skip - {31'd0, (cur_skip != 32'd0)};

        hdr_end = (cur_phase == PH_HEADER) && (cur_idx == 4'd7);
        fmt_end = (cur_phase == PH_FMT) && (cur_idx == FMT_BODY_LEN);
    end

    // Result decision for the current byte.
    always_comb
    begin
        err      = 1'b0;
        err_code = ST_OK;
        if (short_file)
        begin
            err      = 1'b1;
            err_code = ST_TOO_SHORT;
        end
        else
        begin
            unique case (cur_phase)
                PH_MAGIC:
                begin
                    if ((cur_idx == 4'd3 && tag_asm != TAG_RIFF) ||
                        (cur_idx == 4'd11 && tag_asm != TAG_WAVE))
                    begin
                        err      = 1'b1;
                        err_code = ST_BAD_MAGIC;
                    end
                end
                PH_HEADER:
                begin
                    if (hdr_end)
                    begin
                        priority if (cur_tag == TAG_FMT)
                        begin
                            if (fmt_trunc)
                            begin
                                err      = 1'b1;
                                err_code = ST_FMT_TRUNC;
                            end
                            else if (size_asm < 32'd16)
                            begin
                                err      = 1'b1;
                                err_code = ST_FMT_SMALL;
                            end
                        end
                        else if (cur_tag == TAG_DATA)
                        begin
                            err      = 1'b1;
                            err_code = cur_fmt_seen ? ST_OK : ST_MISSING;
                        end
                        else if (overflow)
                        begin
                            err      = 1'b1;
                            err_code = ST_MISSING;
                        end
                    end
                end
                PH_FMT:
                begin
                    if (fmt_end && overflow)
                    begin
                        err      = 1'b1;
                        err_code = ST_MISSING;
                    end
                end
                PH_IDLE, PH_SKIP, PH_DONE:
                begin
                    err = 1'b0;
                end
                default:
                begin
                    err = 1'b0;
                end
            endcase
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (active)
        begin
            if (err)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                unique case (cur_phase)
                    PH_MAGIC:
                    begin
                        phase_next = (cur_idx == 4'd11) ? PH_HEADER : PH_MAGIC;
                    end
                    PH_HEADER:
                    begin
                        if (!hdr_end)
                        begin
                            phase_next = PH_HEADER;
                        end
                        else if (cur_tag == TAG_FMT)
                        begin
                            phase_next = PH_FMT;
                        end
                        else
                        begin
                            phase_next = (gap == 32'd0) ? PH_HEADER : PH_SKIP;
                        end
                    end
                    PH_FMT:
                    begin
                        if (!fmt_end)
                        begin
                            phase_next = PH_FMT;
                        end
                        else
                        begin
                            phase_next = (gap == 32'd0) ? PH_HEADER : PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        phase_next = (skip_dec == 32'd0) ? PH_HEADER : PH_SKIP;
                    end
                    PH_IDLE, PH_DONE:
                    begin
                        phase_next = phase_reg;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Datapath state and the result item.
    always_comb
    begin
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        tag_next      = tag_reg;
        skip_next     = skip_reg;
        rate_next     = rate_reg;
        chan_next     = chan_reg;
        bits_next     = bits_reg;
        fmt_seen_next = fmt_seen_reg;

        if (active)
        begin
            pos_next      = cur_pos;
            tag_next      = cur_tag;
            skip_next     = cur_skip;
            rate_next     = cur_rate;
            chan_next     = cur_chan;
            bits_next     = cur_bits;
            fmt_seen_next = cur_fmt_seen;

            if ((cur_phase == PH_MAGIC && cur_idx != 4'd11) ||
                (cur_phase == PH_HEADER && !hdr_end) ||
                (cur_phase == PH_FMT && !fmt_end))
            begin
                shift_next = cur_idx + 4'd1;
            end
            else
            begin
                shift_next = 4'd0;
            end

            unique case (cur_phase)
                PH_MAGIC:
                begin
                    tag_next = tag_asm;
                end
                PH_HEADER:
                begin
                    if (!cur_idx[2])
                    begin
                        tag_next = tag_asm;
                    end
                    else if (hdr_end && cur_tag == TAG_FMT)
                    begin
                        skip_next     = size_asm - 32'd16;
                        fmt_seen_next = 1'b1;
                    end
                    else
                    begin
                        skip_next = size_asm;
                    end
                end
                PH_FMT:
                begin
                    if (cur_idx == 4'd2)
                    begin
                        chan_next = {8'd0, b};
                    end
                    else if (cur_idx == 4'd3)
                    begin
                        chan_next[15:8] = b;
                    end
                    else if (cur_idx >= 4'd4 && cur_idx <= 4'd7)
                    begin
                        rate_next = (cur_idx == 4'd4) ? {24'd0, b} : cur_rate;
                        rate_next[lane_base +: 8] = b;
                    end
                    else if (cur_idx == 4'd14)
                    begin
                        bits_next = {8'd0, b};
                    end
                    else if (cur_idx == FMT_BODY_LEN)
                    begin
                        bits_next[15:8] = b;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                end
                PH_IDLE, PH_DONE:
                begin
                    skip_next = cur_skip;
                end
                default:
                begin
                    skip_next = cur_skip;
                end
            endcase
        end

        res_valid = active && err;
        result.status        = err_code;
        result.frame_rate    = (err_code == ST_OK) ? cur_rate : 32'd0;
        result.channel_count = (err_code == ST_OK) ? cur_chan : 16'd0;
        result.sample_bits   = (err_code == ST_OK) ? cur_bits : 16'd0;
        result.data_offset   = (err_code == ST_OK) ? body[31:0] : 32'd0;
        result.data_length   = (err_code == ST_OK) ? size_asm : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= 32'd0;
            phase_reg       <= PH_IDLE;
            pos_reg         <= 32'd0;
            shift_reg       <= 4'd0;
            tag_reg         <= 32'd0;
            skip_reg        <= 32'd0;
            rate_reg        <= 32'd0;
            chan_reg        <= 16'd0;
            bits_reg        <= 16'd0;
            fmt_seen_reg    <= 1'b0;
        end
        else
        begin
            if (file_length_we)
            begin
                file_length_reg <= file_length_wdata;
            end
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            tag_reg      <= tag_next;
            skip_reg     <= skip_next;
            rate_reg     <= rate_next;
            chan_reg     <= chan_next;
            bits_reg     <= bits_next;
            fmt_seen_reg <= fmt_seen_next;
        end
    end

`ifndef SYNTHESIS
    // A result only comes from a byte that is actually being parsed.
    a_result_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> item_fire)
        else $error("result without a processed byte");

    // After a result the parse stays finished until the next first byte.
    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (phase_reg == PH_DONE))
        else $error("phase not finished after result");

    // A file shorter than a minimal header is rejected on its first byte.
    a_short_file: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && first && file_length_reg < MIN_FILE_LEN) |->
            (res_valid && result.status == ST_TOO_SHORT))
        else $error("short file not rejected");

    // A good result always carries a parsed fmt chunk.
    a_ok_needs_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && result.status == ST_OK) |-> cur_fmt_seen)
        else $error("ok result without fmt chunk");
`endif

endmodule

@@ rtl/whp_result_stage.sv @@
// Output register that holds one result request until it is taken.
module whp_result_stage
    import whp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_load,
    input  result_t     res_data,
    output logic        stage_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] frame_rate,
    output logic [15:0] channel_count,
    output logic [15:0] sample_bits,
    output logic [31:0] data_offset,
    output logic [31:0] data_length
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign stage_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res_data;
        end
    end

    assign out_valid     = valid_reg;
    assign status        = data_reg.status;
    assign frame_rate    = data_reg.frame_rate;
    assign channel_count = data_reg.channel_count;
    assign sample_bits   = data_reg.sample_bits;
    assign data_offset   = data_reg.data_offset;
    assign data_length   = data_reg.data_length;

endmodule

@@ test/wav_header_checker.sv @@
// Checker for the WAVE header parser: mirrors the parse of each file and compares every result.
`timescale 1ns / 100ps

module wav_header_checker
    import whp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        file_length_we,
    input  logic [31:0] file_length_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        first_flag,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [31:0] frame_rate,
    input  logic [15:0] channel_count,
    input  logic [15:0] sample_bits,
    input  logic [31:0] data_offset,
    input  logic [31:0] data_length,
    output int          failures,
    output int          outstanding
);

    phase_t      ph;
    logic [31:0] flen;
    logic [31:0] pos;
    logic [3:0]  shift;
    logic [31:0] tag;
    logic [31:0] remaining;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [15:0] bits;
    logic        fmt_ok;

    result_t     expected_headers[$];
    result_t     want;
    result_t     made;
    int          mismatches;
    int          headers_seen;

    // Builds the result of a finished parse; the format fields only go out with a clean status.
    function automatic result_t close_parse(input status_t st, input logic [31:0] offset,
                                            input logic [31:0] length);
        result_t r;
        r = '0;
        r.status = st;
        if (st == ST_OK)
        begin
            r.frame_rate = rate;
            r.channel_count = chans;
            r.sample_bits = bits;
            r.data_offset = offset;
            r.data_length = length;
        end
        ph = PH_DONE;
        return r;
    endfunction

    // The next chunk header must fit inside the file; positions are compared without wrapping.
    function automatic bit step_to_next_chunk(input logic [63:0] next_start,
                                              input logic [31:0] gap, output result_t r);
        r = '0;
        if (next_start + 64'd8 > {32'd0, flen})
        begin
            r = close_parse(ST_MISSING, '0, '0);
            return 1'b1;
        end
        shift = '0;
        if (gap == 0)
            ph = PH_HEADER;
        else
        begin
            ph = PH_SKIP;
            remaining = gap;
        end
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                      output result_t r);
        logic [3:0]  idx;
        logic [63:0] body;
        logic [31:0] size_field;
        r = '0;
        if (first)
        begin
            ph = PH_MAGIC;
            pos = '0;
            shift = '0;
            tag = '0;
            remaining = '0;
            rate = '0;
            chans = '0;
            bits = '0;
            fmt_ok = 1'b0;
            if (flen < MIN_FILE_LEN)
            begin
                r = close_parse(ST_TOO_SHORT, '0, '0);
                return 1'b1;
            end
        end
        else
        begin
            if (ph == PH_IDLE || ph == PH_DONE)
                return 1'b0;
            pos = pos + 32'd1;
        end
        idx = shift;
        body = {32'd0, pos} + 64'd1;
        case (ph)
            PH_MAGIC:
            begin
                if (idx[1:0] == 2'd0)
                    tag = '0;
                tag = tag | ({24'd0, b} << (8 * idx[1:0]));
                if ((idx == 4'd3 && tag != TAG_RIFF) || (idx == 4'd11 && tag != TAG_WAVE))
                begin
                    r = close_parse(ST_BAD_MAGIC, '0, '0);
                    return 1'b1;
                end
                if (idx == 4'd11)
                begin
                    ph = PH_HEADER;
                    shift = '0;
                end
                else
                    shift = idx + 4'd1;
            end
            PH_HEADER:
            begin
                if (idx < 4'd4)
                begin
                    if (idx == 4'd0)
                        tag = '0;
                    tag = tag | ({24'd0, b} << (8 * idx[1:0]));
                end
                else
                begin
                    if (idx == 4'd4)
                        remaining = '0;
                    remaining = remaining | ({24'd0, b} << (8 * idx[1:0]));
                end
                if (idx < 4'd7)
                    shift = idx + 4'd1;
                else
                begin
                    size_field = remaining;
                    if (tag == TAG_FMT)
                    begin
                        if (body + 64'd16 > {32'd0, flen})
                        begin
                            r = close_parse(ST_FMT_TRUNC, '0, '0);
                            return 1'b1;
                        end
                        if (size_field < 32'd16)
                        begin
                            r = close_parse(ST_FMT_SMALL, '0, '0);
                            return 1'b1;
                        end
                        fmt_ok = 1'b1;
                        remaining = size_field - 32'd16;
                        shift = '0;
                        ph = PH_FMT;
                    end
                    else if (tag == TAG_DATA)
                    begin
                        // A data chunk ahead of any fmt chunk counts as a missing chunk.
                        r = close_parse(fmt_ok ? ST_OK : ST_MISSING, body[31:0], size_field);
                        return 1'b1;
                    end
                    else
                        return step_to_next_chunk(body + {32'd0, size_field}, size_field, r);
                end
            end
            PH_FMT:
            begin
                case (idx)
                    4'd2: chans = {8'd0, b};
                    4'd3: chans = chans | {b, 8'd0};
                    4'd4: rate = {24'd0, b};
                    4'd5, 4'd6, 4'd7: rate = rate | ({24'd0, b} << (8 * idx[1:0]));
                    4'd14: bits = {8'd0, b};
                    4'd15: bits = bits | {b, 8'd0};
                    default: ;
                endcase
                if (idx < 4'd15)
                    shift = idx + 4'd1;
                else
                    return step_to_next_chunk(body + {32'd0, remaining}, remaining, r);
            end
            PH_SKIP:
            begin
                if (remaining != 0)
                    remaining = remaining - 32'd1;
                if (remaining == 0)
                begin
                    ph = PH_HEADER;
                    shift = '0;
                end
            end
            default: ph = PH_DONE;
        endcase
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph = PH_IDLE;
            flen = '0;
            pos = '0;
            shift = '0;
            tag = '0;
            remaining = '0;
            rate = '0;
            chans = '0;
            bits = '0;
            fmt_ok = 1'b0;
            expected_headers.delete();
            mismatches = 0;
            headers_seen = 0;
            failures <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (file_length_we)
                flen = file_length_wdata;
            if (out_valid && out_ready)
            begin
                headers_seen++;
                if (expected_headers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("header %0d: none expected, got status %0d",
                                 headers_seen, status);
                end
                else
                begin
                    want = expected_headers.pop_front();
                    if (want.status !== status || want.frame_rate !== frame_rate ||
                        want.channel_count !== channel_count ||
                        want.sample_bits !== sample_bits ||
                        want.data_offset !== data_offset || want.data_length !== data_length)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"header %0d: expected st %0d rate %h ch %h bps %h ",
                                      "off %h len %h, got st %0d rate %h ch %h bps %h ",
                                      "off %h len %h"},
                                     headers_seen, want.status, want.frame_rate,
                                     want.channel_count, want.sample_bits,
                                     want.data_offset, want.data_length, status,
                                     frame_rate, channel_count, sample_bits,
                                     data_offset, data_length);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (parse_byte(file_byte, first_flag, made))
                    expected_headers.push_back(made);
            end
            failures <= mismatches;
            outstanding <= expected_headers.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// Testbench top for the WAVE header parser: clock, reset, file stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
    import whp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 300;
    localparam int BYTE_TARGET = 1650;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        file_length_we = 1'b0;
    logic [31:0] file_length_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  file_byte = '0;
    logic        first_flag = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] frame_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    int          failures;
    int          outstanding;

    int          cycles = 0;
    int          bytes_sent = 0;
    int          gap_odds = 4;
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    logic [7:0]  file_bytes[$];

    wav_header_parser dut (.*);
    wav_header_checker header_check (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("wav_header_parser: mismatch");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
    initial
    begin
        int rx_odds;
        rx_odds = 4;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_go)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_go = 1'b0;
            end
            else if (!calm && rx_odds != 0 && $urandom_range(1, rx_odds) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                rx_odds = $urandom_range(0, 6);
        end
    end

    task automatic offer_byte(input logic [7:0] value, input logic first);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        file_byte <= value;
        first_flag <= first;
        // Ready is stable from the falling edge up to the next rising edge.
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic send_file(input bit scrambled);
        foreach (file_bytes[k])
            offer_byte(file_bytes[k], (k == 0) || (scrambled && $urandom_range(0, 9) == 0));
        bytes_sent += file_bytes.size();
    endtask

    task automatic write_file_length(input logic [31:0] len);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // Bytes that make no result may still be inside the pipeline.
        repeat (8) @(posedge clk);
        file_length_we <= 1'b1;
        file_length_wdata <= len;
        @(posedge clk);
        file_length_we <= 1'b0;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            file_bytes.push_back(w[8 * k +: 8]);
    endtask

    task automatic add_chunk(input logic [31:0] id, input logic [31:0] size_field,
                             input int body_len);
        push_word(id);
        push_word(size_field);
        repeat (body_len) file_bytes.push_back(8'($urandom()));
    endtask

    task automatic add_fmt();
        int pick;
        logic [31:0] size_field;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            size_field = 32'd16;
        else if (pick == 7)
            size_field = $urandom_range(17, 24);
        else if (pick == 8)
            size_field = $urandom_range(0, 15);
        else
            size_field = 32'hFFFF_FFF8 + $urandom_range(0, 7);
        add_chunk(TAG_FMT, size_field, (pick == 7) ? int'(size_field) : 16);
    endtask

    initial
    begin
        logic [31:0] len_choice;
        logic [31:0] size_field;
        int n_files;
        int pick;
        int keep;
        bit have_fmt;
        bit noisy;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_file_length('0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hFF, 1'b1);
        offer_byte(8'hA5, 1'b0);
        write_file_length(32'd43);
        offer_byte(8'h52, 1'b1);
        write_file_length(MIN_FILE_LEN);
        file_bytes.delete();
        push_word({8'hFF, TAG_RIFF[23:0]});
        send_file(1'b0);
        file_bytes.delete();
        push_word(TAG_RIFF);
        push_word(32'h00FF_00FF);
        push_word({8'h00, TAG_WAVE[23:0]});
        send_file(1'b0);

        // Each byte opens a too-short file and is a result; a held-off receiver backs up input.
        write_file_length($urandom_range(1, 43));
        hold_go = 1'b1;
        repeat (24) offer_byte(8'($urandom()), 1'b1);
        bytes_sent += 24;

        while (bytes_sent < BYTE_TARGET)
        begin
            calm = (bytes_sent > BYTE_TARGET * 4 / 5);
            pick = $urandom_range(0, 6);
            if (pick == 0)
                len_choice = 32'hFFFF_FFFF;
            else if (pick == 1)
                len_choice = MIN_FILE_LEN;
            else if (pick == 2)
                len_choice = $urandom_range(0, 43);
            else
                len_choice = $urandom_range(44, 140);
            write_file_length(len_choice);
            n_files = (len_choice < MIN_FILE_LEN) ? 2 : $urandom_range(3, 6);
            repeat (n_files)
            begin
                file_bytes.delete();
                noisy = ($urandom_range(0, 9) == 0);
                if (noisy)
                    repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom()));
                else
                begin
                    have_fmt = 1'b0;
                    push_word(TAG_RIFF);
                    push_word($urandom());
                    push_word(TAG_WAVE);
                    if ($urandom_range(0, 11) == 0)
                    begin
                        pick = $urandom_range(0, 11);
                        file_bytes[pick] = file_bytes[pick] ^ 8'(1 << $urandom_range(0, 7));
                    end
                    repeat ($urandom_range(0, 3))
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 6)
                        begin
                            // Oversized chunks never fit, so they are never skipped byte by byte.
                            size_field = ($urandom_range(0, 15) == 0) ?
                                         32'hFFFF_FFF8 + $urandom_range(0, 7) :
                                         $urandom_range(0, 12);
                            add_chunk($urandom(), size_field,
                                      (size_field > 12) ? 0 : int'(size_field));
                        end
                        else if (pick < 9)
                        begin
                            add_fmt();
                            have_fmt = 1'b1;
                        end
                        else
                            add_chunk(TAG_DATA, $urandom(), 0);
                    end
                    if (!have_fmt ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0))
                        add_fmt();
                    add_chunk(TAG_DATA, $urandom(), $urandom_range(0, 3));
                    if ($urandom_range(0, 11) == 0)
                    begin
                        keep = $urandom_range(1, file_bytes.size());
                        file_bytes = file_bytes[0:keep - 1];
                    end
                end
                gap_odds = $urandom_range(0, 6);
                send_file(noisy);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("wav_header_parser: match");
        else
            $display("wav_header_parser: mismatch");
        $finish;
    end

endmodule

@@ wav_header_parser.f @@
rtl/whp_pkg.sv
rtl/whp_input_stage.sv
rtl/whp_parser.sv
rtl/whp_result_stage.sv
rtl/wav_header_parser.sv
test/wav_header_checker.sv
test/testbench.sv
